// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int KEY_BITS     = 32;
  localparam int FIELD_BITS   = 32;
  localparam int CNT_BITS     = $clog2(CAPACITY + 1);
  localparam int IN_TDATA_BITS  = 64;
  localparam int OUT_TDATA_BITS = 200;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_CLEAR  = 2'd3
  } cell_op_e;

  // Broadcast to every cell in the chain
  typedef struct packed {
    cell_op_e                  op;
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]   payload;
  } cell_ctrl_t;

  // What a cell shows to its neighbors
  typedef struct packed {
    logic                       valid;
    logic                       keep;
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]    payload;
  } cell_link_t;

endpackage

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::cell_link_t prev_i,
  input  spq_pkg::cell_link_t next_i,
  output spq_pkg::cell_link_t link_o
);

  import spq_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [PAYLOAD_BITS-1:0]    payload_q, payload_d;
  logic                       keep;

  // Entry stays put on insert when it ranks at or above the new key
  assign keep = valid_q && (key_q >= ctrl_i.key);

  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    payload_d = payload_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (!keep) begin
          if (prev_i.keep) begin
            valid_d   = 1'b1;
            key_d     = ctrl_i.key;
            payload_d = ctrl_i.payload;
          end else begin
            valid_d   = prev_i.valid;
            key_d     = prev_i.key;
            payload_d = prev_i.payload;
          end
        end
      end
      CELL_REMOVE: begin
        valid_d   = next_i.valid;
        key_d     = next_i.key;
        payload_d = next_i.payload;
      end
      CELL_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign link_o.valid   = valid_q;
  assign link_o.keep    = keep;
  assign link_o.key     = key_q;
  assign link_o.payload = payload_q;

endmodule

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted by signed key in a chain of cells.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in a row of cells, highest key at
// cell 0. Every cell compares its own key with the incoming key at once, so an
// insert or a remove is one shift of the whole row; equal keys leave in
// arrival order. For each item, the acceptance edge updates the cells and the
// entry counter, and the following edge captures the front and tail from the
// cells and the count into the output register. A new item is taken only when
// no earlier item is pending and that register is free or being drained, so
// no item is accepted before the last one has reached the output. Every item
// yields exactly one result item. Insert when full, remove when empty and
// clear when empty return ok = 0 and leave the queue untouched.
module sorted_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input item
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [spq_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata_i,  // key, payload
  input  logic [1:0]                          s_axis_tuser_i,  // opcode
  // Result item
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // removed_key, removed_payload, front_key, front_payload, tail_key,
  // tail_payload, entry_count, is_empty, zero pad
  output logic [spq_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata_o,
  output logic                                m_axis_tuser_o   // ok
);

  import spq_pkg::*;

  cell_ctrl_t ctrl;
  cell_link_t links [CAPACITY];
  cell_link_t prev_link [CAPACITY];
  cell_link_t next_link [CAPACITY];

  op_e                   op;
  logic                  accept;
  logic                  op_ok;
  logic                  pend_q;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  ok_q;
  logic [FIELD_BITS-1:0] rkey_q, rpay_q;
  logic                  out_valid_q;
  logic [OUT_TDATA_BITS-1:0] out_data_q, out_data_d;
  logic                  out_ok_q;
  logic [KEY_BITS-1:0]     tail_key;
  logic [PAYLOAD_BITS-1:0] tail_pay;
  logic                    nonempty;

  assign op     = op_e'(s_axis_tuser_i);
  // Take a new item only when no result is in flight and the output drains
  assign s_axis_tready_o = !pend_q && (!out_valid_q || m_axis_tready_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Decide success and the command for the chain
  always_comb begin
    op_ok    = 1'b1;
    count_d  = count_q;
    ctrl.op  = CELL_HOLD;
    ctrl.key = s_axis_tdata_i[KEY_BITS-1:0];
    ctrl.payload = PAYLOAD_BITS'(s_axis_tdata_i[2*FIELD_BITS-1:FIELD_BITS]);
    unique case (op)
      OP_INSERT: begin
        if (count_q == CNT_BITS'(CAPACITY)) begin
          op_ok = 1'b0;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (count_q == '0) begin
          op_ok = 1'b0;
        end else begin
          ctrl.op = CELL_REMOVE;
          count_d = count_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        if (count_q == '0) begin
          op_ok = 1'b0;
        end else begin
          ctrl.op = CELL_CLEAR;
          count_d = '0;
        end
      end
      default: ;
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
      count_d = count_q;
    end
  end

  // Wire up the chain; the head sees a neighbor that always keeps, the tail
  // sees an empty neighbor
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        prev_link[i] = '{valid: 1'b0, keep: 1'b1, key: '0, payload: '0};
      end else begin
        prev_link[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin
        next_link[i] = '{valid: 1'b0, keep: 1'b0, key: '0, payload: '0};
      end else begin
        next_link[i] = links[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_link[g]),
      .next_i (next_link[g]),
      .link_o (links[g])
    );
  end

  // Tail is the last valid cell: valid with an empty neighbor behind it
  always_comb begin
    tail_key = '0;
    tail_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (links[i].valid && !next_link[i].valid) begin
        tail_key = tail_key | links[i].key;
        tail_pay = tail_pay | links[i].payload;
      end
    end
  end

  assign nonempty = links[0].valid;

  always_comb begin
    out_data_d = '0;
    out_data_d[FIELD_BITS-1:0]              = rkey_q;
    out_data_d[2*FIELD_BITS-1:FIELD_BITS]   = rpay_q;
    if (nonempty) begin
      out_data_d[3*FIELD_BITS-1:2*FIELD_BITS] = FIELD_BITS'(links[0].key);
      out_data_d[4*FIELD_BITS-1:3*FIELD_BITS] = FIELD_BITS'(links[0].payload);
      out_data_d[5*FIELD_BITS-1:4*FIELD_BITS] = FIELD_BITS'(tail_key);
      out_data_d[6*FIELD_BITS-1:5*FIELD_BITS] = FIELD_BITS'(tail_pay);
    end
    out_data_d[6*FIELD_BITS+CNT_BITS-1:6*FIELD_BITS] = count_q;
    out_data_d[6*FIELD_BITS+CNT_BITS]                = !nonempty;
  end

  // Control: pending flag, counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= accept;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted item's own outcome until the chain has settled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q   <= op_ok;
      rkey_q <= '0;
      rpay_q <= '0;
      if (op == OP_REMOVE && op_ok) begin
        rkey_q <= FIELD_BITS'(links[0].key);
        rpay_q <= FIELD_BITS'(links[0].payload);
      end
    end
    if (pend_q) begin
      out_data_q <= out_data_d;
      out_ok_q   <= ok_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue: a clocked driver feeds
// bursts of queue operations from a backlog, a clocked monitor predicts each
// result from its own sorted copy of the queue and checks every field.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int LONG_HOLD   = 80;     // receiver hold-off length, cycles
  localparam int RANDOM_OPS  = 1400;
  localparam int DRAIN_EVERY = 300;    // random ops between full drains
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    op_e         op;
    logic [31:0] key;
    logic [31:0] payload;
    bit          drain_first;  // hold this item until all results are back
  } queue_op_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] removed_key;
    logic [31:0] removed_payload;
    logic [31:0] front_key;
    logic [31:0] front_payload;
    logic [31:0] tail_key;
    logic [31:0] tail_payload;
    logic [4:0]  count;
    logic        empty;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;   // key, payload
  logic [1:0]                s_tuser = OP_NOP;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tuser;

  queue_op_t   op_backlog[$];
  status_t     status_fifo[$];

  // Own sorted image of the queue, slot 0 is the front
  logic [31:0] model_key[CAPACITY];
  logic [31:0] model_pay[CAPACITY];
  int          model_count;

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned op_seen[4];
  int unsigned full_rejects, empty_rejects, peak_count;

  int unsigned burst_left, gap_left;
  int unsigned hold_left, holds_done, mode_left;
  int unsigned ready_mode;

  sorted_priority_queue u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one operation to the sorted image and return the status it yields
  function automatic status_t predict_queue_op(op_e op, logic [31:0] key,
                                               logic [31:0] pay);
    status_t r;
    int      pos;
    r    = '0;
    r.ok = 1'b1;
    case (op)
      OP_INSERT: begin
        if (model_count == CAPACITY) begin
          r.ok = 1'b0;
        end else begin
          // equal keys go behind the ones already stored
          pos = 0;
          while (pos < model_count && $signed(model_key[pos]) >= $signed(key))
            pos++;
          for (int i = model_count; i > pos; i--) begin
            model_key[i] = model_key[i-1];
            model_pay[i] = model_pay[i-1];
          end
          model_key[pos] = key;
          model_pay[pos] = pay;
          model_count++;
        end
      end
      OP_REMOVE: begin
        if (model_count == 0) begin
          r.ok = 1'b0;
        end else begin
          r.removed_key     = model_key[0];
          r.removed_payload = model_pay[0];
          for (int i = 1; i < model_count; i++) begin
            model_key[i-1] = model_key[i];
            model_pay[i-1] = model_pay[i];
          end
          model_count--;
        end
      end
      OP_CLEAR: begin
        if (model_count == 0) r.ok = 1'b0;
        else model_count = 0;
      end
      default: ;
    endcase
    if (model_count > 0) begin
      r.front_key     = model_key[0];
      r.front_payload = model_pay[0];
      r.tail_key      = model_key[model_count-1];
      r.tail_payload  = model_pay[model_count-1];
    end
    r.count = model_count[4:0];
    r.empty = (model_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] result %0d %s: got %h expected %h", $realtime, results_seen,
             what, got, want);
    error_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer backlog items in bursts separated by random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic        took;
    int unsigned sent_now;
    bit          can_go;
    queue_op_t   nxt;
    if (!rst_ni) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tuser    <= OP_NOP;
      items_sent <= 0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      took     = s_tvalid && s_tready;
      sent_now = items_sent + (took ? 1 : 0);
      if (took) items_sent <= sent_now;
      if (!s_tvalid || took) begin
        // a drain item waits until the last outstanding result has come back
        can_go = op_backlog.size() != 0 && gap_left == 0 &&
                 (!op_backlog[0].drain_first || sent_now == results_seen);
        if (can_go) begin
          nxt      = op_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt.payload, nxt.key};
          s_tuser  <= nxt.op;
          if (burst_left <= 1) begin
            // mostly short bursts, now and then a long gapless stream
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern with two long hold-offs
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
      mode_left  <= 0;
      ready_mode <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_done < 2 && results_seen >= 300 + 600 * holds_done) begin
      // stall the output long enough for the input side to back up
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
      m_tready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the oldest expectation, then predict the accepted item
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    op_e     op;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.ok              = m_tuser;
        got.removed_key     = m_tdata[31:0];
        got.removed_payload = m_tdata[63:32];
        got.front_key       = m_tdata[95:64];
        got.front_payload   = m_tdata[127:96];
        got.tail_key        = m_tdata[159:128];
        got.tail_payload    = m_tdata[191:160];
        got.count           = m_tdata[196:192];
        got.empty           = m_tdata[197];
        if (status_fifo.size() == 0) begin
          report_mismatch("unexpected result", {31'd0, got.ok}, 32'd0);
        end else begin
          want = status_fifo.pop_front();
          check_field("ok", {31'd0, got.ok}, {31'd0, want.ok});
          check_field("removed_key", got.removed_key, want.removed_key);
          check_field("removed_payload", got.removed_payload, want.removed_payload);
          check_field("front_key", got.front_key, want.front_key);
          check_field("front_payload", got.front_payload, want.front_payload);
          check_field("tail_key", got.tail_key, want.tail_key);
          check_field("tail_payload", got.tail_payload, want.tail_payload);
          check_field("entry_count", {27'd0, got.count}, {27'd0, want.count});
          check_field("is_empty", {31'd0, got.empty}, {31'd0, want.empty});
        end
        results_seen <= results_seen + 1;
      end
      if (s_tvalid && s_tready) begin
        op   = op_e'(s_tuser);
        want = predict_queue_op(op, s_tdata[31:0], s_tdata[63:32]);
        status_fifo.push_back(want);
        op_seen[op]++;
        if (!want.ok && op == OP_INSERT) full_rejects++;
        if (!want.ok && op == OP_REMOVE) empty_rejects++;
        if (model_count > peak_count) peak_count = model_count;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_op(op_e op, logic [31:0] key, logic [31:0] pay, bit drain = 0);
    queue_op_t it;
    it.op          = op;
    it.key         = key;
    it.payload     = pay;
    it.drain_first = drain;
    op_backlog.push_back(it);
  endtask

  // Narrow keys force ties, extremes hit the ends of the signed range
  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0, 1: return $urandom_range(0, 8) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned n_ops, run_len, next_drain;
    op_e         op;

    results_seen  = 0;
    error_count   = 0;
    model_count   = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    peak_count    = 0;
    foreach (op_seen[i]) op_seen[i] = 0;

    // Directed: empty-queue failures, extremes, ties at front and tail
    add_op(OP_REMOVE, 32'h1234_5678, 32'hDEAD_BEEF);
    add_op(OP_CLEAR,  32'h0,         32'h0);
    add_op(OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_op(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
    add_op(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);   // tie with front
    add_op(OP_INSERT, 32'h8000_0000, 32'h0000_0002);   // tie with tail
    add_op(OP_INSERT, 32'h8000_0000, 32'h0000_0003);
    add_op(OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    add_op(OP_NOP,    32'h0,         32'h0);
    add_op(OP_REMOVE, 32'h0,         32'h0);
    add_op(OP_REMOVE, 32'h0,         32'h0);
    add_op(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random: fill runs that overflow, drain runs that underflow, and mixes
    n_ops      = 0;
    next_drain = 0;
    while (n_ops < RANDOM_OPS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          run_len = $urandom_range(8, 20);
          repeat (run_len) begin
            op = ($urandom_range(0, 9) == 0) ? op_e'($urandom_range(1, 3)) : OP_INSERT;
            add_op(op, rand_key(), $urandom, n_ops == next_drain);
            if (n_ops == next_drain) next_drain += DRAIN_EVERY;
            n_ops++;
          end
        end
        3, 4, 5: begin
          run_len = $urandom_range(4, 18);
          repeat (run_len) begin
            op = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_REMOVE;
            add_op(op, rand_key(), $urandom, n_ops == next_drain);
            if (n_ops == next_drain) next_drain += DRAIN_EVERY;
            n_ops++;
          end
        end
        6, 7: begin
          run_len = $urandom_range(4, 16);
          repeat (run_len) begin
            add_op(op_e'($urandom_range(0, 3)), rand_key(), $urandom,
                   n_ops == next_drain);
            if (n_ops == next_drain) next_drain += DRAIN_EVERY;
            n_ops++;
          end
        end
        8: begin
          add_op(OP_CLEAR, $urandom, $urandom, n_ops == next_drain);
          if (n_ops == next_drain) next_drain += DRAIN_EVERY;
          n_ops++;
        end
        default: begin
          add_op(OP_NOP, $urandom, $urandom, n_ops == next_drain);
          if (n_ops == next_drain) next_drain += DRAIN_EVERY;
          n_ops++;
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_backlog.size() != 0 || s_tvalid) @(posedge clk_i);
    while (status_fifo.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d inserts, %0d removes, %0d clears, %0d idle ops; %0d results checked",
             op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_CLEAR],
             op_seen[OP_NOP], results_seen);
    $display("Rejected %0d inserts on full and %0d removes on empty; peak occupancy %0d",
             full_rejects, empty_rejects, peak_count);
    if (error_count == 0 && status_fifo.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sorted_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/tb.sv
